### hdl/tmte_pkg.sv
// ----------------------------------------------------------------------------
// tmte_pkg: shared types and constants of the text mode terminal engine
// Request codes, item layouts, control codes and the command and status
// structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package tmte_pkg;

    localparam int REQ_W     = 2;
    localparam int CODE_W    = 8;
    localparam int COLOR_W   = 4;
    localparam int INDEX_W   = 11;
    localparam int ROW_OUT_W = 5;
    localparam int COL_OUT_W = 7;
    localparam int LOC_W     = 11;
    localparam int CELL_W    = 16;
    localparam int ATTR_W    = 8;

    localparam logic [CODE_W-1:0]  CH_BACKSPACE = 8'h08;
    localparam logic [CODE_W-1:0]  CH_TAB       = 8'h09;
    localparam logic [CODE_W-1:0]  CH_LF        = 8'h0A;
    localparam logic [CODE_W-1:0]  CH_CR        = 8'h0D;
    localparam logic [CODE_W-1:0]  CH_SPACE     = 8'h20;
    localparam logic [COLOR_W-1:0] FG_WHITE     = 4'hF;
    localparam logic [ATTR_W-1:0]  ATTR_RESET   = 8'h0F;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUT   = 2'd0,
        REQ_BLANK = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_READ  = 2'd3
    } t_req;

    typedef struct packed {
        t_req                req_type;
        logic [CODE_W-1:0]   char_code;
        logic [COLOR_W-1:0]  fill_color;
        logic [INDEX_W-1:0]  cell_index;
    } t_in_item;

    typedef struct packed {
        logic [ROW_OUT_W-1:0] cursor_row;
        logic [COL_OUT_W-1:0] cursor_col;
        logic [LOC_W-1:0]     cursor_location;
        logic [CELL_W-1:0]    cell_value;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SHIFT,
        ST_FILL,
        ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_EXEC,
        OP_SHIFT,
        OP_FILL
    } t_dp_op;

    typedef enum logic [1:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_INC
    } t_ptr_op;

    typedef struct packed {
        logic    take_in;
        t_dp_op  op;
        t_ptr_op ptr_op;
        logic    load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic scroll;
        logic clear;
        logic shift_last;
        logic fill_last;
    } t_dp_stat;

endpackage

### hdl/text_mode_terminal_engine.sv
// ----------------------------------------------------------------------------
// text_mode_terminal_engine: character terminal over a text cell store
// Interprets put, colored blank, clear and read requests against a
// ROWS x COLS store of 16-bit cells and reports the cursor for each item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid / o_in_ready carries one request item; output
//   channel o_out_valid / i_out_ready returns one result item per request.
//   i_cfg_we / i_cfg_wdata write the text attribute (reset 8'h0F); write it
//   only while no item is in flight.
//   Each item runs an execute step and a finish step; its result is loaded
//   into the output register in the finish step, where the next item can
//   also be taken while the output register is free.
//   A request that scrolls adds a sweep: the cell store, with one read and
//   one write port, copies one cell per cycle up by one row, then blanks
//   the bottom row one cell per cycle. A clear fills all ROWS*COLS cells.
//   Reset (synchronous, active low) homes the cursor, restores the
//   attribute and drops any pending result; cell contents are left as they
//   are and read as garbage until written.
//   When the receiver stalls, the result holds in the output register and
//   one more item is taken and executed; it then waits in its finish step.
// ----------------------------------------------------------------------------
module text_mode_terminal_engine #(
    parameter int ROWS     = 25,
    parameter int COLS     = 80,
    parameter int TAB_STOP = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [tmte_pkg::ATTR_W-1:0] i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  tmte_pkg::t_in_item          i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output tmte_pkg::t_out_item         o_out_item
);

    // command and status between sequencer and datapath
    tmte_pkg::t_dp_cmd  dp_cmd;
    tmte_pkg::t_dp_stat dp_stat;

    // sequencer: owns both handshakes and the sweep sequencing
    tmte_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    // datapath: cursor, cell store, attribute and result register
    tmte_datapath #(
        .ROWS     (ROWS),
        .COLS     (COLS),
        .TAB_STOP (TAB_STOP)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_item   (i_in_item),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_out_item  (o_out_item)
    );

endmodule

### hdl/tmte_ctrl.sv
// ----------------------------------------------------------------------------
// tmte_ctrl: sequencer of the text mode terminal engine
// Steps each item through execute, optional scroll or fill sweep and result
// hand-off; owns the input ready and the result valid.
// ----------------------------------------------------------------------------
module tmte_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  tmte_pkg::t_dp_stat i_stat,
    output tmte_pkg::t_dp_cmd  o_cmd
);

    tmte_pkg::t_state r_state;
    tmte_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tmte_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_in_ready     = 1'b0;
        o_cmd.take_in  = 1'b0;
        o_cmd.op       = tmte_pkg::OP_NONE;
        o_cmd.ptr_op   = tmte_pkg::PTR_HOLD;
        o_cmd.load_out = 1'b0;
        unique case (r_state)
            tmte_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take_in = 1'b1;
                    n_state       = tmte_pkg::ST_EXEC;
                end
            end
            tmte_pkg::ST_EXEC: begin
                o_cmd.op = tmte_pkg::OP_EXEC;
                priority if (i_stat.clear) begin
                    o_cmd.ptr_op = tmte_pkg::PTR_ZERO;
                    n_state      = tmte_pkg::ST_FILL;
                end else if (i_stat.scroll) begin
                    o_cmd.ptr_op = tmte_pkg::PTR_ZERO;
                    n_state      = tmte_pkg::ST_SHIFT;
                end else begin
                    n_state = tmte_pkg::ST_FINISH;
                end
            end
            tmte_pkg::ST_SHIFT: begin
                o_cmd.op = tmte_pkg::OP_SHIFT;
                if (i_stat.shift_last) begin
                    n_state = tmte_pkg::ST_FILL;
                end else begin
                    o_cmd.ptr_op = tmte_pkg::PTR_INC;
                end
            end
            tmte_pkg::ST_FILL: begin
                o_cmd.op = tmte_pkg::OP_FILL;
                if (i_stat.fill_last) begin
                    n_state = tmte_pkg::ST_FINISH;
                end else begin
                    o_cmd.ptr_op = tmte_pkg::PTR_INC;
                end
            end
            tmte_pkg::ST_FINISH: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_in_ready     = 1'b1;
                    if (i_in_valid) begin
                        o_cmd.take_in = 1'b1;
                        n_state       = tmte_pkg::ST_EXEC;
                    end else begin
                        n_state = tmte_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = tmte_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // no intake while the store is being swept
    a_no_intake_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tmte_pkg::ST_SHIFT || r_state == tmte_pkg::ST_FILL) |-> !o_in_ready)
        else $error("input ready during store sweep");

    // a result is never loaded over one still waiting
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before it was taken");

    // an accepted item goes straight to execution
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == tmte_pkg::ST_EXEC))
        else $error("accepted item not executed");

    // results appear only out of the finish step
    a_valid_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == tmte_pkg::ST_FINISH))
        else $error("result valid raised outside finish step");

endmodule

### hdl/tmte_datapath.sv
// ----------------------------------------------------------------------------
// tmte_datapath: cursor logic, cell store and result register
// Decodes the held request, moves the cursor, writes or reads the cell store,
// and runs the scroll copy and blank fill sweeps under controller command.
// ----------------------------------------------------------------------------
module tmte_datapath #(
    parameter int ROWS     = 25,
    parameter int COLS     = 80,
    parameter int TAB_STOP = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tmte_pkg::ATTR_W-1:0]        i_cfg_wdata,
    input  tmte_pkg::t_in_item                 i_in_item,
    input  tmte_pkg::t_dp_cmd                  i_cmd,
    output tmte_pkg::t_dp_stat                 o_stat,
    output tmte_pkg::t_out_item                o_out_item
);

    localparam int CELL_COUNT = ROWS * COLS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int COL_W      = $clog2(COLS);
    localparam int RN_W       = ROW_W + 1;
    localparam int CN_W       = $clog2(COLS + TAB_STOP + 1);
    localparam int SHIFT_END  = (ROWS - 1) * COLS;
    localparam int TAB_COUNT  = COLS / TAB_STOP + 1;

    logic [tmte_pkg::CELL_W-1:0] mem [CELL_COUNT];

    tmte_pkg::t_in_item          r_req;
    tmte_pkg::t_out_item         r_out;
    logic [tmte_pkg::ATTR_W-1:0] r_attr;
    logic [ROW_W-1:0]            r_row;
    logic [COL_W-1:0]            r_col;
    logic [ADDR_W-1:0]           r_ptr;
    logic [tmte_pkg::CELL_W-1:0] r_rdata;

    logic [tmte_pkg::CELL_W-1:0] blank;
    logic [ADDR_W-1:0]           loc;
    logic                        idx_ok;
    logic [CN_W-1:0]             col_ext;
    logic [CN_W-1:0]             col_n;
    logic [CN_W-1:0]             tab_nxt;
    logic [RN_W-1:0]             row_n;
    logic                        scroll;
    logic [ROW_W-1:0]            row_fin;
    logic [COL_W-1:0]            col_fin;
    logic                        wr_exec;
    logic [tmte_pkg::CELL_W-1:0] exec_data;
    logic                        wr_en;
    logic [ADDR_W-1:0]           wr_addr;
    logic [tmte_pkg::CELL_W-1:0] wr_data;
    logic                        rd_en;
    logic [ADDR_W-1:0]           rd_addr;

    assign blank  = {r_attr, tmte_pkg::CH_SPACE};
    assign loc    = ADDR_W'(r_row) * ADDR_W'(COLS) + ADDR_W'(r_col);
    assign idx_ok = int'(r_req.cell_index) < CELL_COUNT;

    // cursor step for the held request
    always_comb begin
        col_ext   = CN_W'(r_col);
        col_n     = col_ext;
        row_n     = RN_W'(r_row);
        wr_exec   = 1'b0;
        exec_data = blank;
        tab_nxt   = CN_W'(COLS);
        for (int k = TAB_COUNT; k >= 1; k--) begin
            if (CN_W'(k * TAB_STOP) > col_ext) begin
                tab_nxt = CN_W'(k * TAB_STOP);
            end
        end
        unique case (r_req.req_type)
            tmte_pkg::REQ_PUT: begin
                priority if (r_req.char_code == tmte_pkg::CH_BACKSPACE && r_col != '0) begin
                    col_n = col_ext - CN_W'(1);
                end else if (r_req.char_code == tmte_pkg::CH_TAB) begin
                    col_n = tab_nxt;
                end else if (r_req.char_code == tmte_pkg::CH_CR) begin
                    col_n = '0;
                end else if (r_req.char_code == tmte_pkg::CH_LF) begin
                    col_n = '0;
                    row_n = row_n + RN_W'(1);
                end else if (r_req.char_code >= tmte_pkg::CH_SPACE
                             && !r_req.char_code[tmte_pkg::CODE_W-1]) begin
                    wr_exec   = 1'b1;
                    exec_data = {r_attr, r_req.char_code};
                    col_n     = col_ext + CN_W'(1);
                end else begin
                    col_n = col_ext;
                end
            end
            tmte_pkg::REQ_BLANK: begin
                wr_exec   = 1'b1;
                exec_data = {r_req.fill_color, tmte_pkg::FG_WHITE, tmte_pkg::CH_SPACE};
                col_n     = col_ext + CN_W'(1);
            end
            tmte_pkg::REQ_CLEAR: begin
                col_n = '0;
                row_n = '0;
            end
            tmte_pkg::REQ_READ: begin
                col_n = col_ext;
            end
            default: col_n = col_ext;
        endcase
        // wrap past the last column
        if (col_n >= CN_W'(COLS)) begin
            col_n = '0;
            row_n = row_n + RN_W'(1);
        end
        scroll  = row_n >= RN_W'(ROWS);
        row_fin = scroll ? ROW_W'(ROWS - 1) : row_n[ROW_W-1:0];
        col_fin = col_n[COL_W-1:0];
    end

    always_comb begin
        o_stat.scroll     = scroll;
        o_stat.clear      = r_req.req_type == tmte_pkg::REQ_CLEAR;
        o_stat.shift_last = r_ptr == ADDR_W'(SHIFT_END);
        o_stat.fill_last  = r_ptr == ADDR_W'(CELL_COUNT - 1);
    end

    // store port selection
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = loc;
        wr_data = exec_data;
        rd_en   = 1'b0;
        rd_addr = ADDR_W'(r_req.cell_index);
        unique case (i_cmd.op)
            tmte_pkg::OP_EXEC: begin
                wr_en = wr_exec;
                rd_en = r_req.req_type == tmte_pkg::REQ_READ && idx_ok;
            end
            tmte_pkg::OP_SHIFT: begin
                // the write stores the cell that was read in the previous cycle
                wr_en   = r_ptr != '0;
                wr_addr = r_ptr - ADDR_W'(1);
                wr_data = r_rdata;
                rd_en   = r_ptr != ADDR_W'(SHIFT_END);
                rd_addr = r_ptr + ADDR_W'(COLS);
            end
            tmte_pkg::OP_FILL: begin
                wr_en   = 1'b1;
                wr_addr = r_ptr;
                wr_data = blank;
            end
            tmte_pkg::OP_NONE: begin
                wr_en = 1'b0;
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= tmte_pkg::ATTR_RESET;
            r_row  <= '0;
            r_col  <= '0;
            r_ptr  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_attr <= i_cfg_wdata;
            end
            if (i_cmd.op == tmte_pkg::OP_EXEC) begin
                r_row <= row_fin;
                r_col <= col_fin;
            end
            unique case (i_cmd.ptr_op)
                tmte_pkg::PTR_ZERO: r_ptr <= '0;
                tmte_pkg::PTR_INC:  r_ptr <= r_ptr + ADDR_W'(1);
                tmte_pkg::PTR_HOLD: r_ptr <= r_ptr;
                default:            r_ptr <= r_ptr;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_req <= i_in_item;
        end
        if (i_cmd.load_out) begin
            r_out.cursor_row      <= tmte_pkg::ROW_OUT_W'(r_row);
            r_out.cursor_col      <= tmte_pkg::COL_OUT_W'(r_col);
            r_out.cursor_location <= tmte_pkg::LOC_W'(loc);
            r_out.cell_value      <= (r_req.req_type == tmte_pkg::REQ_READ && idx_ok)
                                     ? r_rdata : '0;
        end
    end

    assign o_out_item = r_out;

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the text mode terminal engine
// Streams put, colored blank, clear and read requests into the engine, keeps
// a cycle-free model of the cell store and cursor, and checks every result
// item field by field. Phases vary the text attribute and the idle and stall
// pattern on both channels.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS     = 25;
    localparam int COLS     = 80;
    localparam int TAB_STOP = 8;
    localparam int CELLS    = ROWS * COLS;

    localparam int PHASES           = 8;
    localparam int ITEMS_PER_PHASE  = 212;
    localparam int WATCHDOG_LIMIT   = 20000;
    localparam int SETTLE_CYCLES    = 8;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_cfg_we    = 1'b0;
    logic [tmte_pkg::ATTR_W-1:0]   i_cfg_wdata = '0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_ready;
    tmte_pkg::t_in_item            i_in_item   = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    tmte_pkg::t_out_item           o_out_item;

    // Requests waiting to be driven, and cursor/cell results still owed.
    tmte_pkg::t_in_item  request_q[$];
    tmte_pkg::t_out_item cursor_report_q[$];

    // Shadow of the console: cell store, cursor and text attribute.
    logic [tmte_pkg::CELL_W-1:0] cell_shadow [CELLS];
    int                          shadow_row;
    int                          shadow_col;
    logic [tmte_pkg::ATTR_W-1:0] shadow_attr;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count     = 0;
    int quiet_cycles   = 0;

    text_mode_terminal_engine #(
        .ROWS     (ROWS),
        .COLS     (COLS),
        .TAB_STOP (TAB_STOP)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Console shadow
    // ------------------------------------------------------------------------

    // Store a cell at the cursor and advance the column; the wrap and scroll
    // are handled afterwards by settle_shadow_cursor.
    function automatic void write_shadow_cell(logic [tmte_pkg::CELL_W-1:0] value);
        int loc;
        loc = shadow_row * COLS + shadow_col;
        if (loc < CELLS)
            cell_shadow[loc] = value;
        shadow_col++;
    endfunction

    // Wrap past the last column, then scroll up one row past the last row.
    function automatic void settle_shadow_cursor();
        int k;
        if (shadow_col >= COLS) begin
            shadow_col = 0;
            shadow_row++;
        end
        if (shadow_row >= ROWS) begin
            for (k = 0; k < (ROWS - 1) * COLS; k++)
                cell_shadow[k] = cell_shadow[k + COLS];
            for (k = (ROWS - 1) * COLS; k < CELLS; k++)
                cell_shadow[k] = {shadow_attr, tmte_pkg::CH_SPACE};
            shadow_row = ROWS - 1;
        end
    endfunction

    // Apply one request to the shadow and return the result item it owes.
    function automatic tmte_pkg::t_out_item apply_console_request(tmte_pkg::t_in_item req);
        tmte_pkg::t_out_item         report;
        logic [tmte_pkg::CELL_W-1:0] cell_rd;
        int                          k;
        cell_rd = '0;
        case (req.req_type)
            tmte_pkg::REQ_PUT: begin
                if (req.char_code == tmte_pkg::CH_BACKSPACE && shadow_col != 0) begin
                    shadow_col--;
                end else if (req.char_code == tmte_pkg::CH_TAB) begin
                    shadow_col = (shadow_col / TAB_STOP + 1) * TAB_STOP;
                end else if (req.char_code == tmte_pkg::CH_CR) begin
                    shadow_col = 0;
                end else if (req.char_code == tmte_pkg::CH_LF) begin
                    shadow_col = 0;
                    shadow_row++;
                end else if (req.char_code >= tmte_pkg::CH_SPACE
                             && req.char_code[7] == 1'b0) begin
                    // Printable range; codes with the top bit set are negative
                    // as signed chars and drop through untouched.
                    write_shadow_cell({shadow_attr, req.char_code});
                end
                settle_shadow_cursor();
            end
            tmte_pkg::REQ_BLANK: begin
                write_shadow_cell({req.fill_color, tmte_pkg::FG_WHITE, tmte_pkg::CH_SPACE});
                settle_shadow_cursor();
            end
            tmte_pkg::REQ_CLEAR: begin
                for (k = 0; k < CELLS; k++)
                    cell_shadow[k] = {shadow_attr, tmte_pkg::CH_SPACE};
                shadow_row = 0;
                shadow_col = 0;
            end
            default: begin
                // Reads past the store return zero.
                if (req.cell_index < CELLS)
                    cell_rd = cell_shadow[req.cell_index];
            end
        endcase
        report.cursor_row      = tmte_pkg::ROW_OUT_W'(shadow_row);
        report.cursor_col      = tmte_pkg::COL_OUT_W'(shadow_col);
        report.cursor_location = tmte_pkg::LOC_W'(shadow_row * COLS + shadow_col);
        report.cell_value      = cell_rd;
        return report;
    endfunction

    // ------------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------------

    function automatic tmte_pkg::t_in_item make_request(
        tmte_pkg::t_req                   kind,
        logic [tmte_pkg::CODE_W-1:0]      code,
        logic [tmte_pkg::COLOR_W-1:0]     color,
        logic [tmte_pkg::INDEX_W-1:0]     index);
        tmte_pkg::t_in_item req;
        req.req_type   = kind;
        req.char_code  = code;
        req.fill_color = color;
        req.cell_index = index;
        return req;
    endfunction

    // Mostly printable text, a sprinkle of control codes, blanks and reads,
    // with rare clears so the cursor keeps reaching the bottom and scrolling.
    // Fields that a request ignores still carry random bits.
    function automatic tmte_pkg::t_in_item random_request();
        tmte_pkg::t_in_item req;
        int                 pick;
        req.req_type   = tmte_pkg::REQ_PUT;
        req.char_code  = tmte_pkg::CODE_W'($urandom_range(255));
        req.fill_color = tmte_pkg::COLOR_W'($urandom_range(15));
        req.cell_index = tmte_pkg::INDEX_W'($urandom_range(2047));
        pick = $urandom_range(999);
        if (pick < 550) begin
            req.char_code = tmte_pkg::CODE_W'($urandom_range(127, 32));
        end else if (pick < 600) begin
            case ($urandom_range(2))
                0:       req.char_code = tmte_pkg::CH_BACKSPACE;
                1:       req.char_code = tmte_pkg::CH_TAB;
                default: req.char_code = tmte_pkg::CH_CR;
            endcase
        end else if (pick < 615) begin
            req.char_code = tmte_pkg::CH_LF;
        end else if (pick < 690) begin
            // Noise: any code byte, control or high-bit.
        end else if (pick < 790) begin
            req.req_type = tmte_pkg::REQ_BLANK;
        end else if (pick < 997) begin
            req.req_type = tmte_pkg::REQ_READ;
            // Hold most reads inside the store; the rest take any index, in or past it.
            if ($urandom_range(9) != 0)
                req.cell_index = tmte_pkg::INDEX_W'($urandom_range(CELLS - 1));
        end else begin
            req.req_type = tmte_pkg::REQ_CLEAR;
        end
        return req;
    endfunction

    // Queue n random items; now and then a run of line feeds pushes the
    // cursor toward the bottom row and, from a low enough row, through scrolls.
    task automatic queue_random_requests(int n);
        int queued;
        int run_len;
        queued = 0;
        while (queued < n) begin
            if ($urandom_range(99) == 0) begin
                run_len = $urandom_range(20, 1);
                repeat (run_len) begin
                    request_q.push_back(make_request(tmte_pkg::REQ_PUT, tmte_pkg::CH_LF,
                        tmte_pkg::COLOR_W'($urandom_range(15)),
                        tmte_pkg::INDEX_W'($urandom_range(2047))));
                end
                queued += run_len;
            end else begin
                request_q.push_back(random_request());
                queued++;
            end
        end
    endtask

    // Hold until nothing is queued, nothing is on the input channel and no
    // result is owed. Sampled on the falling edge to stay clear of the
    // driver and monitor.
    task automatic wait_console_idle();
        @(negedge i_clk);
        while (request_q.size() != 0 || i_in_valid || cursor_report_q.size() != 0)
            @(negedge i_clk);
    endtask

    // Write the text attribute; only called while the engine is idle.
    task automatic write_text_attr(logic [tmte_pkg::ATTR_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        shadow_attr  = value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: present queued items, hold them until accepted, and update the
    // shadow on every accepted item.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                cursor_report_q.push_back(apply_console_request(i_in_item));
            // Advance only when the slot is empty or its item just went in;
            // a single assignment per edge keeps valid steady across items.
            if (!i_in_valid || o_in_ready) begin
                if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_item  <= request_q.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each accepted result against the oldest owed report and
    // stall the output channel at the phase's rate.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        tmte_pkg::t_out_item want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (cursor_report_q.size() == 0) begin
                    $error("result item with no request outstanding");
                    fail_count++;
                end else begin
                    want = cursor_report_q.pop_front();
                    check_field("cursor_row", want.cursor_row, o_out_item.cursor_row);
                    check_field("cursor_col", want.cursor_col, o_out_item.cursor_col);
                    check_field("cursor_location", want.cursor_location,
                                o_out_item.cursor_location);
                    check_field("cell_value", want.cell_value, o_out_item.cell_value);
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: drop the run when neither channel moves for too long. The
    // limit covers a full scroll or clear walk plus a long output stall.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, directed items, then phases of random traffic.
    // ------------------------------------------------------------------------
    initial begin
        shadow_row  = 0;
        shadow_col  = 0;
        shadow_attr = tmte_pkg::ATTR_RESET;

        // Directed part, under the reset attribute and with no idling. The
        // store starts unwritten, so reads before the clear touch only cells
        // just written or indexes past the end of the store.
        request_q.push_back(make_request(tmte_pkg::REQ_READ,  8'h00, 4'h0, 11'd2047));
        request_q.push_back(make_request(tmte_pkg::REQ_READ,  8'h00, 4'h0, 11'd2000));
        request_q.push_back(make_request(tmte_pkg::REQ_PUT,   8'h41, 4'h0, 11'd0));
        request_q.push_back(make_request(tmte_pkg::REQ_PUT,   tmte_pkg::CH_SPACE, 4'h0,
                                         11'd0));
        request_q.push_back(make_request(tmte_pkg::REQ_PUT,   8'h7F, 4'h0, 11'd0));
        request_q.push_back(make_request(tmte_pkg::REQ_READ,  8'h00, 4'h0, 11'd0));
        request_q.push_back(make_request(tmte_pkg::REQ_READ,  8'h00, 4'h0, 11'd1));
        request_q.push_back(make_request(tmte_pkg::REQ_READ,  8'h00, 4'h0, 11'd2));
        request_q.push_back(make_request(tmte_pkg::REQ_CLEAR, 8'hFF, 4'hF, 11'd2047));
        // Backspace at column 0 stays put; unnamed control and high codes
        // are ignored.
        request_q.push_back(make_request(tmte_pkg::REQ_PUT,   tmte_pkg::CH_BACKSPACE, 4'h0,
                                         11'd0));
        request_q.push_back(make_request(tmte_pkg::REQ_PUT,   8'h00, 4'h0, 11'd0));
        request_q.push_back(make_request(tmte_pkg::REQ_PUT,   8'h1F, 4'h0, 11'd0));
        request_q.push_back(make_request(tmte_pkg::REQ_PUT,   8'h80, 4'h0, 11'd0));
        request_q.push_back(make_request(tmte_pkg::REQ_PUT,   8'hFF, 4'hF, 11'd2047));
        request_q.push_back(make_request(tmte_pkg::REQ_PUT,   tmte_pkg::CH_TAB, 4'h0, 11'd0));
        request_q.push_back(make_request(tmte_pkg::REQ_PUT,   8'h78, 4'h0, 11'd0));
        request_q.push_back(make_request(tmte_pkg::REQ_PUT,   tmte_pkg::CH_TAB, 4'h0, 11'd0));
        request_q.push_back(make_request(tmte_pkg::REQ_PUT,   tmte_pkg::CH_BACKSPACE, 4'h0,
                                         11'd0));
        request_q.push_back(make_request(tmte_pkg::REQ_PUT,   tmte_pkg::CH_CR, 4'h0, 11'd0));
        request_q.push_back(make_request(tmte_pkg::REQ_BLANK, 8'h00, 4'h0, 11'd0));
        request_q.push_back(make_request(tmte_pkg::REQ_BLANK, 8'h00, 4'hF, 11'd0));
        request_q.push_back(make_request(tmte_pkg::REQ_PUT,   tmte_pkg::CH_LF, 4'h0, 11'd0));
        request_q.push_back(make_request(tmte_pkg::REQ_READ,  8'h00, 4'h0, 11'd0));
        request_q.push_back(make_request(tmte_pkg::REQ_READ,  8'h00, 4'h0, 11'd1999));
        request_q.push_back(make_request(tmte_pkg::REQ_READ,  8'h00, 4'h0, 11'd8));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_console_idle();
            // Every result has come back; the engine is idle before the
            // register is touched.
            repeat (2) @(negedge i_clk);
            case (phase)
                0:       write_text_attr(8'h00);
                1:       write_text_attr(8'hFF);
                4:       write_text_attr(tmte_pkg::ATTR_RESET);
                6:       write_text_attr(8'h00);
                default: write_text_attr(tmte_pkg::ATTR_W'($urandom_range(255)));
            endcase
            case (phase % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 76;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 76;
                end
                default: begin
                    send_idle_pct  = 7;
                    recv_stall_pct = 7;
                end
            endcase
            // Pause the sender halfway until the engine has drained.
            queue_random_requests(ITEMS_PER_PHASE / 2);
            wait_console_idle();
            queue_random_requests(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);
        end

        wait_console_idle();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### text_mode_terminal_engine.f
hdl/tmte_pkg.sv
hdl/tmte_ctrl.sv
hdl/tmte_datapath.sv
hdl/text_mode_terminal_engine.sv
tb/tb.sv
